/* design/dfd_pkg.sv */
`timescale 1ns / 1ps

package dfd_pkg;

    localparam int MAX_LEN_DEF     = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 4;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 33;
    localparam int DIST_W   = 17;

    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

    // smallest operand whose square exceeds SQ_MAX
    localparam int OP_W = 17;
    localparam logic [SQ_W-1:0] SQ_ROOT_LIM = 33'd92682;

    // integer square root: one result bit per step
    localparam int ROOT_W     = 35;
    localparam int ROOT_STEPS = 18;
    localparam int ROOT_K_W   = 5;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    typedef struct packed {
        logic                       series_sel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_req_t;

    typedef struct packed {
        logic [SQ_W-1:0]   dist_squared;
        logic [DIST_W-1:0] distance;
        status_t           status;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_UPD,
        ST_ROOT_GO,
        ST_ROOT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_first;
        logic wr_second;
        logic cell_rd;
        logic cell_mul;
        logic cell_upd;
        logic first_row;
        logic first_col;
        logic root_start;
        logic load_out;
        logic load_empty;
        logic dropped;
    } cmd_t;

    typedef struct packed {
        logic root_done;
    } dp_stat_t;

endpackage

/* design/dfd_isqrt.sv */
`timescale 1ns / 1ps

module dfd_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dfd_pkg::SQ_W-1:0]  value,
    output logic                      done,
    output logic [dfd_pkg::DIST_W-1:0] root
);
    import dfd_pkg::*;

    logic [ROOT_W-1:0]   v_reg, v_next;
    logic [ROOT_W-1:0]   res_reg, res_next;
    logic [ROOT_K_W-1:0] k_reg, k_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W-1:0]   bit_val;
    logic [ROOT_W-1:0]   trial;

    assign bit_val = ROOT_W'(1) << {k_reg, 1'b0};
    assign trial   = res_reg + bit_val;

    always_comb begin
        v_next    = v_reg;
        res_next  = res_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            v_next    = ROOT_W'(value);
            res_next  = '0;
            k_next    = ROOT_K_W'(ROOT_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_val;
            end else begin
                res_next = res_reg >> 1;
            end
            if (k_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg   <= v_next;
        res_reg <= res_next;
        k_reg   <= k_next;
    end

    assign done = done_reg;
    assign root = res_reg[DIST_W-1:0];

endmodule

/* design/dfd_datapath.sv */
`timescale 1ns / 1ps

module dfd_datapath #(
    parameter int MAX_LEN     = dfd_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = dfd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = dfd_pkg::FRAC_BITS_DEF,
    parameter int IDX_W       = $clog2(MAX_LEN)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dfd_pkg::cmd_t                       cmd,
    input  logic signed [dfd_pkg::SAMPLE_W-1:0] sample,
    input  logic [IDX_W-1:0]                    wr_addr,
    input  logic [IDX_W-1:0]                    row,
    input  logic [IDX_W-1:0]                    col,
    output dfd_pkg::dp_stat_t                   stat,
    output dfd_pkg::out_req_t                   m_req
);
    import dfd_pkg::*;

    localparam int RAW_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DXS_W = IDX_W + FRAC_BITS;

    logic signed [SAMPLE_BITS-1:0] first_mem  [MAX_LEN];
    logic signed [SAMPLE_BITS-1:0] second_mem [MAX_LEN];
    logic [SQ_W-1:0]               cost_mem   [MAX_LEN];

    logic [SAMPLE_W-1:0]           sample_u;
    logic [RAW_W-1:0]              raw;
    logic signed [SAMPLE_BITS-1:0] stored;

    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg;
    logic [SQ_W-1:0]               up_reg, diag_reg, left_reg;
    logic [SQ_W-1:0]               sqx_reg, sqy_reg;
    logic                          sat_reg;
    out_req_t                      out_reg;

    logic [IDX_W-1:0]              dx;
    logic [DXS_W-1:0]              dxs;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          dy;
    logic [OP_W-1:0]               dx_op, dy_op;
    logic [2*OP_W-1:0]             px, py;
    logic                          sat;

    logic [SQ_W:0]                 sum;
    logic [SQ_W-1:0]               pt;
    logic [SQ_W-1:0]               min_ud, min3, pred, cell_cost;

    logic                          root_done;
    logic [DIST_W-1:0]             root;

    assign sample_u = sample;
    assign raw      = RAW_W'(sample_u);
    assign stored   = raw[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_first) begin
            first_mem[wr_addr] <= stored;
        end
        if (cmd.cell_rd) begin
            a_reg <= first_mem[row];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_second) begin
            second_mem[wr_addr] <= stored;
        end
        if (cmd.cell_rd) begin
            b_reg <= second_mem[col];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cell_upd) begin
            cost_mem[col] <= cell_cost;
        end
        if (cmd.cell_rd) begin
            up_reg <= cost_mem[col];
        end
    end

    // point distance: clamp operands whose square alone saturates
    assign dx    = (row > col) ? (row - col) : (col - row);
    assign dxs   = DXS_W'(dx) << FRAC_BITS;
    assign diff  = {a_reg[SAMPLE_BITS-1], a_reg} - {b_reg[SAMPLE_BITS-1], b_reg};
    assign dy    = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
    assign sat   = (SQ_W'(dy) >= SQ_ROOT_LIM) || (SQ_W'(dxs) >= SQ_ROOT_LIM);
    assign dx_op = OP_W'(dxs);
    assign dy_op = OP_W'(dy);
    assign px    = dx_op * dx_op;
    assign py    = dy_op * dy_op;

    always_ff @(posedge aclk) begin
        if (cmd.cell_mul) begin
            sqx_reg <= px[SQ_W-1:0];
            sqy_reg <= py[SQ_W-1:0];
            sat_reg <= sat;
        end
    end

    // max-of-min recurrence
    assign sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign pt     = (sat_reg || sum[SQ_W]) ? SQ_MAX : sum[SQ_W-1:0];
    assign min_ud = (up_reg < diag_reg) ? up_reg : diag_reg;
    assign min3   = (min_ud < left_reg) ? min_ud : left_reg;

    always_comb begin
        if (cmd.first_row && cmd.first_col) begin
            pred = '0;
        end else if (cmd.first_row) begin
            pred = left_reg;
        end else if (cmd.first_col) begin
            pred = up_reg;
        end else begin
            pred = min3;
        end
        cell_cost = (pred > pt) ? pred : pt;
    end

    always_ff @(posedge aclk) begin
        if (cmd.cell_upd) begin
            left_reg <= cell_cost;
            if (!cmd.first_row) begin
                diag_reg <= up_reg;
            end
        end
    end

    dfd_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.root_start),
        .value   (left_reg),
        .done    (root_done),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.load_empty) begin
                out_reg.dist_squared <= '0;
                out_reg.distance     <= '0;
                out_reg.status       <= STATUS_EMPTY;
            end else begin
                out_reg.dist_squared <= left_reg;
                out_reg.distance     <= root;
                out_reg.status       <= cmd.dropped ? STATUS_DROPPED : STATUS_OK;
            end
        end
    end

    assign stat.root_done = root_done;
    assign m_req          = out_reg;

endmodule

/* design/dfd_ctrl.sv */
`timescale 1ns / 1ps

module dfd_ctrl #(
    parameter int MAX_LEN = dfd_pkg::MAX_LEN_DEF,
    parameter int IDX_W   = $clog2(MAX_LEN)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dfd_pkg::in_req_t   s_req,
    output logic               m_valid,
    input  logic               m_ready,
    input  dfd_pkg::dp_stat_t  stat,
    output dfd_pkg::cmd_t      cmd,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [IDX_W-1:0]   row,
    output logic [IDX_W-1:0]   col
);
    import dfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             overflow_reg, overflow_next;
    logic             empty_reg, empty_next;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;

    logic             first_full, second_full;
    logic [CNT_W-1:0] row_last, col_last;

    assign first_full  = first_count_reg == CNT_W'(MAX_LEN);
    assign second_full = second_count_reg == CNT_W'(MAX_LEN);
    assign row_last    = first_count_reg - 1'b1;
    assign col_last    = second_count_reg - 1'b1;

    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        empty_next        = empty_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        cmd               = '0;
        cmd.load_empty    = empty_reg;
        cmd.dropped       = overflow_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_req.series_sel) begin
                        if (first_full) begin
                            overflow_next = 1'b1;
                        end else begin
                            cmd.wr_first     = 1'b1;
                            first_count_next = first_count_reg + 1'b1;
                        end
                    end else begin
                        if (second_full) begin
                            overflow_next = 1'b1;
                        end else begin
                            cmd.wr_second     = 1'b1;
                            second_count_next = second_count_reg + 1'b1;
                        end
                        if (s_req.last) begin
                            row_next = '0;
                            col_next = '0;
                            if (first_count_reg == '0 || second_count_next == '0) begin
                                empty_next = 1'b1;
                                state_next = ST_FINISH;
                            end else begin
                                empty_next = 1'b0;
                                state_next = ST_RD;
                            end
                        end
                    end
                end
            end
            ST_RD: begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.cell_mul = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                cmd.cell_upd  = 1'b1;
                cmd.first_row = row_reg == '0;
                cmd.first_col = col_reg == '0;
                if (col_reg == col_last[IDX_W-1:0]) begin
                    col_next = '0;
                    if (row_reg == row_last[IDX_W-1:0]) begin
                        state_next = ST_ROOT_GO;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end else begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_ROOT_GO: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (stat.root_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out      = 1'b1;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            empty_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
            row_reg          <= '0;
            col_reg          <= '0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            empty_reg        <= empty_next;
            m_valid_reg      <= m_valid_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign wr_addr = s_req.series_sel ? second_count_reg[IDX_W-1:0]
                                      : first_count_reg[IDX_W-1:0];
    assign row     = row_reg;
    assign col     = col_reg;

    a_cell_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cell_upd |-> (CNT_W'(row_reg) < first_count_reg)
                         && (CNT_W'(col_reg) < second_count_reg))
        else $error("cell index outside loaded series");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending one");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (first_count_reg == '0) && (second_count_reg == '0)
                         && !overflow_reg)
        else $error("counts not cleared after result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_count_reg <= CNT_W'(MAX_LEN)) && (second_count_reg <= CNT_W'(MAX_LEN)))
        else $error("series count beyond capacity");

    a_root_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.root_done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

endmodule

/* design/discrete_frechet_distance.sv */
// Discrete Frechet distance of two sample series.
// Request channel s_valid/s_ready/s_req: each request carries one sample,
// series_sel picks the series it is appended to, and last on a second-series
// sample starts the computation. Samples load while s_ready is high.
// Result channel m_valid/m_ready/m_req: one result per start, holding the
// squared distance, its floor square root and a status code.
// Computation walks the N x M cost table through one shared cell unit with
// a memory-backed cost row, taking each cell through read, multiply and
// update states, then runs an iterative square root on the final cost.
// An empty series gives an empty-status result without computation.
// s_ready is low while a computation runs. The finished result sits in an
// output register; loading of new samples proceeds while it waits, and a
// following computation holds its result until m_ready frees the register.
// Reset (aresetn low at a clock edge) empties both series, clears the
// dropped-sample flag and any pending result; sample memories need no clear.
`timescale 1ns / 1ps

module discrete_frechet_distance #(
    parameter int MAX_LEN     = dfd_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = dfd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = dfd_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dfd_pkg::in_req_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output dfd_pkg::out_req_t m_req
);
    import dfd_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);

    cmd_t             cmd;
    dp_stat_t         stat;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;

    dfd_ctrl #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .row     (row),
        .col     (col)
    );

    dfd_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_req.sample),
        .wr_addr (wr_addr),
        .row     (row),
        .col     (col),
        .stat    (stat),
        .m_req   (m_req)
    );

endmodule
